// ===== src/pas_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pas_pkg
// Shared types and constants of the process admission scheduler: request and
// result words, event and operation codes, and the control structs that pass
// between the queue, the running table and the sequencer.
// ----------------------------------------------------------------------------
package pas_pkg;

	// configuration port
	localparam int APB_ADDR_W = 3;
	localparam int SLOTS_W    = 5;

	typedef enum logic {
		REG_TOTAL_MEMORY = 1'b0,
		REG_MAX_RUNNING  = 1'b1
	} reg_idx_t;

	// request operation codes
	typedef enum logic {
		OP_ADD  = 1'b0,
		OP_KILL = 1'b1
	} op_t;

	// result event codes
	typedef enum logic [2:0] {
		EV_REJECTED   = 3'd0,
		EV_QUEUED     = 3'd1,
		EV_QUEUE_FULL = 3'd2,
		EV_KILLED     = 3'd3,
		EV_NOT_FOUND  = 3'd4,
		EV_STARTED    = 3'd5
	} event_t;

	// most starts issued after one request
	localparam int STARTS_W = 5;
	localparam logic [STARTS_W-1:0] MAX_STARTS = 5'd16;

	// request word
	typedef struct packed {
		op_t         operation;
		logic [31:0] job_id;
		logic [31:0] memory_need;
	} req_t;

	// result word
	typedef struct packed {
		event_t             event_res;
		logic [31:0]        job_id_out;
		logic [31:0]        job_memory;
		logic [31:0]        free_memory_out;
		logic [SLOTS_W-1:0] free_slots_out;
		logic               last;
	} res_t;

	// configuration registers
	typedef struct packed {
		logic [31:0]        total_memory;
		logic [SLOTS_W-1:0] max_running;
	} cfg_t;

	// one job as held in either store
	typedef struct packed {
		logic [31:0] id;
		logic [31:0] mem;
	} job_entry_t;

	// wait queue control and status
	typedef struct packed {
		logic push;
		logic pop;
		logic rd;
	} wq_cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
	} wq_stat_t;

	// running table control and status
	typedef struct packed {
		logic rd;
		logic kill;
		logic start;
	} run_cmd_t;

	typedef struct packed {
		logic [31:0]        free_memory;
		logic [SLOTS_W-1:0] free_slots;
	} run_stat_t;

endpackage

// ===== src/pas_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pas_cfg
// Configuration register file behind the APB-style port: total memory and
// running limit. Registers are decoded on the word address only.
// ----------------------------------------------------------------------------
module pas_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [pas_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	output pas_pkg::cfg_t                  cfg
);

	pas_pkg::reg_idx_t                 sel;
	logic                              wr_en;
	logic [31:0]                       total_q;
	logic [pas_pkg::SLOTS_W-1:0]       max_run_q;

	assign sel    = pas_pkg::reg_idx_t'(paddr[2]);
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;

	// register write on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q   <= '0;
			max_run_q <= '0;
		end else if (wr_en) begin
			unique case (sel)
				pas_pkg::REG_TOTAL_MEMORY: total_q   <= pwdata;
				pas_pkg::REG_MAX_RUNNING:  max_run_q <= pwdata[pas_pkg::SLOTS_W-1:0];
			endcase
		end
	end

	// read back
	always_comb begin
		unique case (sel)
			pas_pkg::REG_TOTAL_MEMORY: prdata = total_q;
			pas_pkg::REG_MAX_RUNNING:  prdata = {{(32 - pas_pkg::SLOTS_W){1'b0}}, max_run_q};
		endcase
	end

	assign cfg.total_memory = total_q;
	assign cfg.max_running  = max_run_q;

endmodule

// ===== src/pas_wait_q.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pas_wait_q
// Circular wait queue of jobs in a synchronous memory with head pointer and
// fill count. Push writes at the tail, head reads return on the next cycle.
// ----------------------------------------------------------------------------
module pas_wait_q #(
	parameter int WAIT_DEPTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  pas_pkg::wq_cmd_t    cmd,
	input  pas_pkg::job_entry_t push_entry,
	output pas_pkg::job_entry_t head_entry,
	output pas_pkg::wq_stat_t   stat
);

	localparam int IDX_W = $clog2(WAIT_DEPTH);
	localparam int CNT_W = $clog2(WAIT_DEPTH + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WAIT_DEPTH - 1);
	localparam logic [CNT_W:0]   DEPTH_X  = (CNT_W + 1)'(WAIT_DEPTH);
	localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(WAIT_DEPTH);

	pas_pkg::job_entry_t wait_mem_q [WAIT_DEPTH];
	pas_pkg::job_entry_t head_rd_q;
	logic [IDX_W-1:0]    head_q;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W:0]      tail_sum;
	logic [CNT_W:0]      tail_wrap;
	logic [IDX_W-1:0]    tail_idx;

	// tail is head plus count, wrapped once
	always_comb begin
		tail_sum  = (CNT_W + 1)'(head_q) + (CNT_W + 1)'(count_q);
		tail_wrap = (tail_sum >= DEPTH_X) ? (tail_sum - DEPTH_X) : tail_sum;
		tail_idx  = tail_wrap[IDX_W-1:0];
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			wait_mem_q[tail_idx] <= push_entry;
		end
		if (cmd.rd) begin
			head_rd_q <= wait_mem_q[head_q];
		end
	end

	// head and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (cmd.push) begin
			count_q <= count_q + 1'b1;
		end else if (cmd.pop) begin
			head_q  <= (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
			count_q <= count_q - 1'b1;
		end
	end

	assign head_entry = head_rd_q;
	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == DEPTH_C);

endmodule

// ===== src/pas_run_tbl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pas_run_tbl
// Running job table: entries in a synchronous memory, valid bits in flops,
// running memory sum and count, and the registered free memory and free slot
// figures derived from them and the configuration.
// ----------------------------------------------------------------------------
module pas_run_tbl #(
	parameter int RUN_SLOTS = 16
) (
	input  logic                                           clk,
	input  logic                                           arst_n,
	input  pas_pkg::cfg_t                                  cfg,
	input  pas_pkg::run_cmd_t                              cmd,
	input  logic [((RUN_SLOTS > 1) ? $clog2(RUN_SLOTS) : 1)-1:0] rd_addr,
	input  pas_pkg::job_entry_t                            start_entry,
	output pas_pkg::job_entry_t                            rd_entry,
	output logic                                           rd_live,
	output pas_pkg::run_stat_t                             stat
);

	localparam int SLOT_W = (RUN_SLOTS > 1) ? $clog2(RUN_SLOTS) : 1;
	localparam int CNT_W  = $clog2(RUN_SLOTS + 1);
	localparam int USED_W = 32 + CNT_W;
	localparam int CMP_W  = (CNT_W > pas_pkg::SLOTS_W) ? CNT_W : pas_pkg::SLOTS_W;

	pas_pkg::job_entry_t         run_mem_q [RUN_SLOTS];
	pas_pkg::job_entry_t         rd_entry_q;
	logic                        rd_live_q;
	logic [SLOT_W-1:0]           rd_addr_q;
	logic [RUN_SLOTS-1:0]        run_valid_q;
	logic [USED_W-1:0]           used_q;
	logic [CNT_W-1:0]            count_q;
	logic [SLOT_W-1:0]           slot_q;
	logic [SLOT_W-1:0]           free_idx;
	logic [31:0]                 free_mem_q;
	logic [pas_pkg::SLOTS_W-1:0] free_slots_q;
	logic [CMP_W-1:0]            lim;
	logic [CMP_W-1:0]            max_x;
	logic [CMP_W-1:0]            cnt_x;
	logic [CMP_W-1:0]            slots_left;
	logic [31:0]                 mem_left;

	// lowest free entry
	always_comb begin
		free_idx = '0;
		for (int i = RUN_SLOTS - 1; i >= 0; i--) begin
			if (!run_valid_q[i]) begin
				free_idx = SLOT_W'(i);
			end
		end
	end

	// free figures from the running sum and count
	always_comb begin
		max_x      = CMP_W'(cfg.max_running);
		lim        = (max_x > CMP_W'(RUN_SLOTS)) ? CMP_W'(RUN_SLOTS) : max_x;
		cnt_x      = CMP_W'(count_q);
		slots_left = (cnt_x >= lim) ? '0 : (lim - cnt_x);
		mem_left   = (used_q >= USED_W'(cfg.total_memory)) ? '0
			: (cfg.total_memory - used_q[31:0]);
	end

	// table storage, search read port and start write port
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			run_mem_q[slot_q] <= start_entry;
		end
		if (cmd.rd) begin
			rd_entry_q <= run_mem_q[rd_addr];
			rd_live_q  <= run_valid_q[rd_addr];
			rd_addr_q  <= rd_addr;
		end
		slot_q <= free_idx;
	end

	// valid bits and accounting; a kill removes the entry last read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_valid_q  <= '0;
			used_q       <= '0;
			count_q      <= '0;
			free_mem_q   <= '0;
			free_slots_q <= '0;
		end else begin
			if (cmd.kill) begin
				run_valid_q[rd_addr_q] <= 1'b0;
				used_q                 <= used_q - USED_W'(rd_entry_q.mem);
				count_q                <= count_q - 1'b1;
			end else if (cmd.start) begin
				run_valid_q[slot_q] <= 1'b1;
				used_q              <= used_q + USED_W'(start_entry.mem);
				count_q             <= count_q + 1'b1;
			end
			free_mem_q   <= mem_left;
			free_slots_q <= slots_left[pas_pkg::SLOTS_W-1:0];
		end
	end

	assign rd_entry         = rd_entry_q;
	assign rd_live          = rd_live_q;
	assign stat.free_memory = free_mem_q;
	assign stat.free_slots  = free_slots_q;

endmodule

// ===== src/process_admission_scheduler_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// process_admission_scheduler_top
// Admits jobs against a memory budget and a running limit: add requests go
// to a FIFO wait queue, kill requests free a running entry, and after every
// request waiting heads are started in order while they fit.
//
//   channel   direction   handshake                 word
//   in        input       in_valid / in_stall       pas_pkg::req_t
//   out       output      out_valid / out_stall     pas_pkg::res_t
//   cfg       input       psel/penable/pwrite       32-bit registers at 0, 4
//
// An add passes ADD; a kill searches the table in KSRCH, reading one entry
// per cycle from the run memory, and passes SETTLE on a hit. Each start
// then reads the head in HRD, checks it in HCHK and passes SETTLE (at most
// 16 starts per request); a head too large for free memory stops at HCHK.
// Reset clears queue pointers, valid bits and accounting; the stores
// themselves are not cleared and need no sweep.
// One request is worked at a time; a new word is taken while the last
// result still waits in the output register. Output stall holds the
// sequencer at the next result it has to hand over.
// ----------------------------------------------------------------------------
module process_admission_scheduler_top #(
	parameter int WAIT_DEPTH = 16,
	parameter int RUN_SLOTS  = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [pas_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  pas_pkg::req_t                  in_req,
	output logic                           out_valid,
	input  logic                           out_stall,
	output pas_pkg::res_t                  out_res
);

	localparam int SLOT_W  = (RUN_SLOTS > 1) ? $clog2(RUN_SLOTS) : 1;
	localparam int ISSUE_W = $clog2(RUN_SLOTS + 1);

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_ADD    = 7'b0000010,
		S_KSRCH  = 7'b0000100,
		S_SETTLE = 7'b0001000,
		S_HRD    = 7'b0010000,
		S_HCHK   = 7'b0100000,
		S_FIN    = 7'b1000000
	} state_t;

	state_t                         state_q;
	state_t                         state_d;
	pas_pkg::cfg_t                  cfg;
	pas_pkg::req_t                  req_q;
	pas_pkg::wq_cmd_t               wq_cmd;
	pas_pkg::wq_stat_t              wq_stat;
	pas_pkg::job_entry_t            push_entry;
	pas_pkg::job_entry_t            head_entry;
	pas_pkg::run_cmd_t              run_cmd;
	pas_pkg::run_stat_t             run_stat;
	pas_pkg::job_entry_t            rd_entry;
	logic                           rd_live;
	logic [SLOT_W-1:0]              rd_addr;
	logic [ISSUE_W-1:0]             issue_q;
	logic                           chk_vld_s1;
	logic                           issue_go;
	logic                           hit;
	logic [pas_pkg::STARTS_W-1:0]   starts_q;
	pas_pkg::event_t                pend_ev_q;
	logic [31:0]                    pend_id_q;
	logic [31:0]                    pend_mem_q;
	logic                           pend_load;
	pas_pkg::event_t                pend_ev_d;
	logic [31:0]                    pend_id_d;
	logic [31:0]                    pend_mem_d;
	logic                           out_load;
	logic                           out_last;
	logic                           can_load;
	logic                           accept;
	pas_pkg::res_t                  out_q;
	logic                           out_valid_q;

	pas_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pas_wait_q #(
		.WAIT_DEPTH (WAIT_DEPTH)
	) u_wait_q (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (wq_cmd),
		.push_entry (push_entry),
		.head_entry (head_entry),
		.stat       (wq_stat)
	);

	pas_run_tbl #(
		.RUN_SLOTS (RUN_SLOTS)
	) u_run_tbl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.cmd         (run_cmd),
		.rd_addr     (rd_addr),
		.start_entry (head_entry),
		.rd_entry    (rd_entry),
		.rd_live     (rd_live),
		.stat        (run_stat)
	);

	assign in_stall        = (state_q != S_IDLE);
	assign accept          = in_valid & ~in_stall;
	assign can_load        = ~out_valid_q | ~out_stall;
	assign push_entry.id   = req_q.job_id;
	assign push_entry.mem  = req_q.memory_need;
	assign issue_go        = (issue_q < ISSUE_W'(RUN_SLOTS));
	assign rd_addr         = issue_q[SLOT_W-1:0];
	assign hit             = chk_vld_s1 & rd_live & (rd_entry.id == req_q.job_id);

	// sequencer: request event, then the start loop; a result is held back
	// until the next one is known so that the final one carries last
	always_comb begin
		state_d    = state_q;
		wq_cmd     = '0;
		run_cmd    = '0;
		pend_load  = 1'b0;
		pend_ev_d  = pend_ev_q;
		pend_id_d  = req_q.job_id;
		pend_mem_d = req_q.memory_need;
		out_load   = 1'b0;
		out_last   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = (in_req.operation == pas_pkg::OP_KILL) ? S_KSRCH : S_ADD;
				end
			end
			S_ADD: begin
				pend_load = 1'b1;
				state_d   = S_HRD;
				priority if (req_q.memory_need > cfg.total_memory) begin
					pend_ev_d = pas_pkg::EV_REJECTED;
				end else if (wq_stat.full) begin
					pend_ev_d = pas_pkg::EV_QUEUE_FULL;
				end else begin
					pend_ev_d   = pas_pkg::EV_QUEUED;
					wq_cmd.push = 1'b1;
				end
			end
			S_KSRCH: begin
				priority if (hit) begin
					run_cmd.kill = 1'b1;
					pend_load    = 1'b1;
					pend_ev_d    = pas_pkg::EV_KILLED;
					pend_mem_d   = rd_entry.mem;
					state_d      = S_SETTLE;
				end else if (!chk_vld_s1 && !issue_go) begin
					pend_load  = 1'b1;
					pend_ev_d  = pas_pkg::EV_NOT_FOUND;
					pend_mem_d = '0;
					state_d    = S_HRD;
				end else begin
					run_cmd.rd = issue_go;
				end
			end
			S_SETTLE: begin
				state_d = S_HRD;
			end
			S_HRD: begin
				if (wq_stat.empty || (run_stat.free_slots == '0)
					|| (starts_q == pas_pkg::MAX_STARTS)) begin
					state_d = S_FIN;
				end else begin
					wq_cmd.rd = 1'b1;
					state_d   = S_HCHK;
				end
			end
			S_HCHK: begin
				if (head_entry.mem > run_stat.free_memory) begin
					state_d = S_FIN;
				end else if (can_load) begin
					out_load      = 1'b1;
					pend_load     = 1'b1;
					pend_ev_d     = pas_pkg::EV_STARTED;
					pend_id_d     = head_entry.id;
					pend_mem_d    = head_entry.mem;
					wq_cmd.pop    = 1'b1;
					run_cmd.start = 1'b1;
					state_d       = S_SETTLE;
				end
			end
			S_FIN: begin
				if (can_load) begin
					out_load = 1'b1;
					out_last = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			issue_q     <= '0;
			chk_vld_s1  <= 1'b0;
			starts_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				issue_q    <= '0;
				chk_vld_s1 <= 1'b0;
				starts_q   <= '0;
			end else begin
				if (state_q == S_KSRCH) begin
					chk_vld_s1 <= run_cmd.rd;
				end
				if (run_cmd.rd) begin
					issue_q <= issue_q + 1'b1;
				end
				if (run_cmd.start) begin
					starts_q <= starts_q + 1'b1;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request, held-back result and output word; free figures are taken
	// when the held result leaves, before the next start takes effect
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= in_req;
		end
		if (pend_load) begin
			pend_ev_q  <= pend_ev_d;
			pend_id_q  <= pend_id_d;
			pend_mem_q <= pend_mem_d;
		end
		if (out_load) begin
			out_q.event_res       <= pend_ev_q;
			out_q.job_id_out      <= pend_id_q;
			out_q.job_memory      <= pend_mem_q;
			out_q.free_memory_out <= run_stat.free_memory;
			out_q.free_slots_out  <= run_stat.free_slots;
			out_q.last            <= out_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_q;

endmodule

// ===== src/pas_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pas_chk
// Port checker for the process admission scheduler, bound to the top level:
// output stall hold, one request at a time, result order, not-found memory.
// ----------------------------------------------------------------------------
module pas_chk (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_stall,
	input logic          out_valid,
	input logic          out_stall,
	input pas_pkg::res_t out_res
);

	logic prev_last_q;

	// last flag of the most recent delivered word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_last_q <= 1'b1;
		end else if (out_valid && !out_stall) begin
			prev_last_q <= out_res.last;
		end
	end

	// a stalled result word holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_res))
		else $error("result word changed under stall");

	// a taken request blocks the input until its work is done
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second request taken while one is in work");

	// a request opens with its own event and only starts follow it
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((out_res.event_res == pas_pkg::EV_STARTED) == !prev_last_q))
		else $error("result order broken across requests");

	// an unknown job reports no memory
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_res.event_res == pas_pkg::EV_NOT_FOUND)
		|-> (out_res.job_memory == '0))
		else $error("not found result carries memory");

endmodule

bind process_admission_scheduler_top pas_chk u_pas_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_res   (out_res)
);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the process admission scheduler. A scoreboard
// class keeps its own copy of the wait queue, running table and free
// accounting, predicts the result words of every accepted request and checks
// them in order. Directed requests cover rejection, queue full, kill misses,
// strict FIFO blocking, saturated accounting and a full start burst; random
// phases under several register settings follow, with random gaps on both
// channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
	import pas_pkg::*;

	localparam int WAIT_DEPTH    = 16;
	localparam int RUN_SLOTS     = 16;
	localparam int SETTLE_CYCLES = 100;
	localparam int SQUEEZE_HOLD  = 400;
	localparam int CYCLE_LIMIT   = 400000;

	// job admission predictor and store of expected result words
	class admission_scoreboard;
		logic [31:0] total_mem;
		logic [4:0]  max_run;
		logic [31:0] wait_id [WAIT_DEPTH];
		logic [31:0] wait_mem [WAIT_DEPTH];
		int unsigned wait_rd;
		int unsigned wait_cnt;
		logic [31:0] run_id [RUN_SLOTS];
		logic [31:0] run_mem [RUN_SLOTS];
		bit          run_live [RUN_SLOTS];
		logic [31:0] free_mem;
		logic [4:0]  free_slot;
		res_t        expected_results[$];
		int unsigned errors;

		function new();
			total_mem = '0;
			max_run   = '0;
			wait_rd   = 0;
			wait_cnt  = 0;
			errors    = 0;
			foreach (run_live[i]) run_live[i] = 1'b0;
			refresh_free();
		endfunction

		// free memory and slots from the running table, saturated at zero
		function void refresh_free();
			logic [63:0] used;
			int unsigned cnt;
			int unsigned lim;
			used = '0;
			cnt  = 0;
			lim  = (max_run > RUN_SLOTS) ? RUN_SLOTS : max_run;
			foreach (run_live[i]) if (run_live[i]) begin
				used += run_mem[i];
				cnt++;
			end
			free_mem  = (used >= total_mem) ? 32'd0 : total_mem - used[31:0];
			free_slot = (cnt >= lim) ? 5'd0 : 5'(lim - cnt);
		endfunction

		function res_t make_event(event_t ev, logic [31:0] id, logic [31:0] mem);
			res_t w;
			w.event_res       = ev;
			w.job_id_out      = id;
			w.job_memory      = mem;
			w.free_memory_out = free_mem;
			w.free_slots_out  = free_slot;
			w.last            = 1'b0;
			return w;
		endfunction

		function void note_config(reg_idx_t idx, logic [31:0] value);
			if (idx == REG_TOTAL_MEMORY)
				total_mem = value;
			else
				max_run = value[4:0];
			refresh_free();
		endfunction

		// work out the result words of one accepted request
		function void note_request(req_t r);
			res_t        burst[$];
			int          hit;
			int          slot;
			int unsigned starts;
			int unsigned tail;
			int unsigned h;
			if (r.operation == OP_ADD) begin
				if (r.memory_need > total_mem) begin
					burst.push_back(make_event(EV_REJECTED, r.job_id, r.memory_need));
				end else if (wait_cnt >= WAIT_DEPTH) begin
					burst.push_back(make_event(EV_QUEUE_FULL, r.job_id, r.memory_need));
				end else begin
					tail = (wait_rd + wait_cnt) % WAIT_DEPTH;
					wait_id[tail]  = r.job_id;
					wait_mem[tail] = r.memory_need;
					wait_cnt++;
					burst.push_back(make_event(EV_QUEUED, r.job_id, r.memory_need));
				end
			end else begin
				// lowest live entry with a matching id
				hit = -1;
				for (int i = 0; i < RUN_SLOTS; i++) if (run_live[i] && run_id[i] == r.job_id) begin
					hit = i;
					break;
				end
				if (hit < 0) begin
					burst.push_back(make_event(EV_NOT_FOUND, r.job_id, 32'd0));
				end else begin
					run_live[hit] = 1'b0;
					refresh_free();
					burst.push_back(make_event(EV_KILLED, r.job_id, run_mem[hit]));
				end
			end
			// start waiting heads in strict order while they fit
			starts = 0;
			while (starts < MAX_STARTS && wait_cnt > 0 && free_slot > 0) begin
				h = wait_rd;
				if (wait_mem[h] > free_mem) break;
				slot = -1;
				for (int i = 0; i < RUN_SLOTS; i++) if (!run_live[i]) begin
					slot = i;
					break;
				end
				if (slot < 0) break;
				run_live[slot] = 1'b1;
				run_id[slot]   = wait_id[h];
				run_mem[slot]  = wait_mem[h];
				wait_rd        = (h + 1) % WAIT_DEPTH;
				wait_cnt--;
				free_mem  -= wait_mem[h];
				free_slot -= 5'd1;
				burst.push_back(make_event(EV_STARTED, wait_id[h], wait_mem[h]));
				starts++;
			end
			burst[burst.size() - 1].last = 1'b1;
			foreach (burst[i]) expected_results.push_back(burst[i]);
		endfunction

		function void field_check(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected %h, got %h", name, want, got);
				errors++;
			end
		endfunction

		// compare one accepted result word with the oldest prediction
		function void check_result(res_t got);
			res_t want;
			if (expected_results.size() == 0) begin
				$error("result word with none predicted: event %0d id %h",
					got.event_res, got.job_id_out);
				errors++;
				return;
			end
			want = expected_results.pop_front();
			field_check("event_res", want.event_res, got.event_res);
			field_check("job_id_out", want.job_id_out, got.job_id_out);
			field_check("job_memory", want.job_memory, got.job_memory);
			field_check("free_memory_out", want.free_memory_out, got.free_memory_out);
			field_check("free_slots_out", want.free_slots_out, got.free_slots_out);
			field_check("last", want.last, got.last);
		endfunction

		// id of a random running job, or a small id when none runs
		function logic [31:0] running_id();
			int unsigned live[$];
			foreach (run_live[i]) if (run_live[i]) live.push_back(i);
			if (live.size() == 0) return $urandom_range(15);
			return run_id[live[$urandom_range(live.size() - 1)]];
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [31:0]           pwdata;
	logic [31:0]           prdata;
	logic                  pready;
	logic                  in_valid;
	logic                  in_stall;
	req_t                  in_req;
	logic                  out_valid;
	logic                  out_stall;
	res_t                  out_res;

	admission_scoreboard sb = new();
	int unsigned         cycles = 0;
	bit                  src_calm = 1'b0;
	bit                  snk_calm = 1'b0;
	bit                  squeeze = 1'b0;
	bit                  squeezed = 1'b0;

	process_admission_scheduler_top #(
		.WAIT_DEPTH(WAIT_DEPTH),
		.RUN_SLOTS (RUN_SLOTS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_req   (in_req),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_res  (out_res)
	);

	always #6 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// gap before a word, with calm stretches of no idling
	function automatic int unsigned pick_gap(ref bit calm);
		if ($urandom_range(19) == 0) calm = ~calm;
		return calm ? 0 : $urandom_range(14);
	endfunction

	// apb write, setup then access; select stays up for the next write
	task automatic write_reg(reg_idx_t idx, logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sb.note_config(idx, value);
	endtask

	task automatic configure(logic [31:0] total, logic [31:0] max_jobs);
		write_reg(REG_TOTAL_MEMORY, total);
		write_reg(REG_MAX_RUNNING, max_jobs);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// offer one request word and hold it until taken
	task automatic send_req(op_t op, logic [31:0] id, logic [31:0] need);
		int unsigned gap;
		req_t        r;
		r.operation   = op;
		r.job_id      = id;
		r.memory_need = need;
		gap = pick_gap(src_calm);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_req   <= r;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_request(r);
	endtask

	// drop valid, let every predicted word arrive, then let the block go idle
	task automatic drain_results();
		in_valid <= 1'b0;
		while (sb.expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// random mix of adds and kills sized against the current budget
	task automatic run_random(int unsigned count);
		logic [31:0] tot;
		logic [31:0] id;
		logic [31:0] need;
		for (int n = 0; n < count; n++) begin
			tot = sb.total_mem;
			if ($urandom_range(99) < 55) begin
				id = ($urandom_range(3) == 0) ? $urandom : $urandom_range(15);
				case ($urandom_range(9))
					0:       need = $urandom;
					1:       need = tot;
					2:       need = tot + 32'd1;
					default: need = $urandom_range(tot >> 2);
				endcase
				send_req(OP_ADD, id, need);
			end else begin
				case ($urandom_range(9))
					0:       id = $urandom;
					1:       id = $urandom_range(15);
					default: id = sb.running_id();
				endcase
				send_req(OP_KILL, id, $urandom);
			end
		end
	endtask

	// result side: random stalls, one long hold-off on request
	initial begin : result_sink
		int unsigned gap;
		out_stall <= 1'b1;
		@(posedge arst_n);
		forever begin
			gap = pick_gap(snk_calm);
			if (squeeze && !squeezed) begin
				gap      = SQUEEZE_HOLD;
				squeezed = 1'b1;
			end
			if (gap != 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			sb.check_result(out_res);
		end
	end

	initial begin : stimulus
		arst_n   <= 1'b0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		in_valid <= 1'b0;
		in_req   <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// two slots, small budget
		configure(32'd1000, 32'd2);
		send_req(OP_ADD, 32'd1, 32'd0);
		send_req(OP_ADD, 32'd2, 32'd1000);
		send_req(OP_ADD, 32'd3, 32'd1001);
		send_req(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_req(OP_ADD, 32'hFFFF_FFFF, 32'd1000);
		// head needs all memory, the zero-need job behind it must wait
		send_req(OP_ADD, 32'd4, 32'd0);
		send_req(OP_KILL, 32'd5, 32'hFFFF_FFFF);
		send_req(OP_KILL, 32'd1, 32'd0);
		send_req(OP_KILL, 32'd2, 32'd0);
		send_req(OP_ADD, 32'd0, 32'd0);
		send_req(OP_ADD, 32'd9, 32'd10);
		send_req(OP_ADD, 32'd9, 32'd20);
		drain_results();

		// no slots and a budget below what runs: both saturate, queue fills
		configure(32'd500, 32'd0);
		send_req(OP_KILL, 32'hFFFF_FFFF, 32'd0);
		for (int i = 0; i < 14; i++)
			send_req(OP_ADD, (i[0] ? 32'hAAAA_AAA0 : 32'h5555_5550) + i, 32'd37 * i);
		drain_results();

		// full start burst once the last running job goes
		configure(32'hFFFF_FFFF, 32'd16);
		send_req(OP_KILL, 32'd4, 32'd0);
		run_random(35);
		drain_results();

		// output held off for a long stretch while requests keep coming
		configure(32'd3000, 32'd3);
		squeeze = 1'b1;
		run_random(50);
		drain_results();

		configure(32'd1, 32'd1);
		run_random(25);
		drain_results();

		configure(32'd0, 32'd5);
		run_random(15);
		drain_results();

		// limit above the table size acts as a full table
		configure(32'h8000_0000, 32'd31);
		run_random(35);
		drain_results();

		if (sb.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== files.f =====
src/pas_pkg.sv
src/pas_cfg.sv
src/pas_wait_q.sv
src/pas_run_tbl.sv
src/process_admission_scheduler_top.sv
src/pas_chk.sv
tb/sv/tb_top.sv
